// ===== src/hcbp_pkg.sv =====
// Package for the Huffman code bit packer: shared widths, action codes and types.
// Used by every module of the block; depends on nothing.
package hcbp_pkg;

    localparam int CODE_W = 32;
    localparam int LEN_W = 6;
    localparam int SYM_W = 8;
    localparam int BYTE_W = 8;
    localparam int PART_W = 7;
    localparam int ACC_W = 39;
    localparam int TOTAL_W = 6;
    localparam int ACTION_W = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } hcbp_entry_t;

    typedef struct packed {
        logic               busy;
        logic [TOTAL_W-1:0] pending;
    } hcbp_stat_t;

endpackage

// ===== src/hcbp_front.sv =====
// Front end: accepts requests, writes and reads the code table, classifies actions.
// Depends on hcbp_pkg; feeds hcbp_queue.
module hcbp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hcbp_pkg::ACTION_W-1:0] action,
    input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]   code_word,
    input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
    output logic                          push_valid,
    input  logic                          push_ready,
    output hcbp_pkg::hcbp_entry_t         push_entry
);
    import hcbp_pkg::*;

    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    logic [LEN_W+CODE_W-1:0] table_mem [SYMBOL_COUNT];
    logic [CODE_W-1:0]       rd_code_reg;
    logic [LEN_W-1:0]        rd_len_reg;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_flush_reg;
    logic                    s1_flush_next;

    logic                    accept;
    logic                    in_range;
    logic                    do_load;
    logic                    do_read;
    logic [LEN_W-1:0]        clen;
    logic [CODE_W:0]         mask_wide;
    logic [CODE_W-1:0]       masked_code;
    logic [IDX_W-1:0]        idx;

    assign in_ready = !s1_valid_reg || push_ready;
    assign accept = in_valid && in_ready;
    assign in_range = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign idx = symbol[IDX_W-1:0];
    assign do_load = accept && (action == ACT_LOAD) && in_range;
    assign do_read = accept && (action == ACT_ENCODE) && in_range;
    assign clen = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;
    assign mask_wide = ((CODE_W + 1)'(1) << clen) - (CODE_W + 1)'(1);
    assign masked_code = code_word & mask_wide[CODE_W-1:0];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_flush_next = s1_flush_reg;
        if (accept)
        begin
            s1_valid_next = do_read || (action == ACT_FLUSH);
            s1_flush_next = (action == ACT_FLUSH);
        end
        else if (push_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_flush_reg <= s1_flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            table_mem[idx] <= {clen, masked_code};
        end
        if (do_read)
        begin
            {rd_len_reg, rd_code_reg} <= table_mem[idx];
        end
    end

    assign push_valid = s1_valid_reg;
    assign push_entry.flush = s1_flush_reg;
    assign push_entry.code = rd_code_reg;
    assign push_entry.len = rd_len_reg;

endmodule

// ===== src/hcbp_queue.sv =====
// Two-entry queue between the front end and the packing back end.
// Depends on hcbp_pkg.
module hcbp_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_valid,
    output logic                        push_ready,
    input  hcbp_pkg::hcbp_entry_t       push_entry,
    output logic                        pop_valid,
    input  logic                        pop_ready,
    output hcbp_pkg::hcbp_entry_t       pop_entry,
    output logic [hcbp_pkg::QCNT_W-1:0] count
);
    import hcbp_pkg::*;

    hcbp_entry_t         slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;
    assign pop_entry = slots[rd_ptr_reg];
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/hcbp_back.sv =====
// Back end: bit accumulator that merges codes and emits bytes one per cycle when not stalled.
// Depends on hcbp_pkg; drains hcbp_queue and drives the output register.
module hcbp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  hcbp_pkg::hcbp_entry_t       pop_entry,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0] out_byte,
    output logic                        out_last,
    output hcbp_pkg::hcbp_stat_t        stat
);
    import hcbp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic               state_reg;
    logic               state_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               ovalid_reg;
    logic               ovalid_next;
    logic [BYTE_W-1:0]  obyte_reg;
    logic [BYTE_W-1:0]  obyte_next;
    logic               olast_reg;
    logic               olast_next;

    logic [2:0]         pcount;
    logic [BYTE_W-1:0]  pmask;
    logic [PART_W-1:0]  part;
    logic [3:0]         pad_shift;
    logic [BYTE_W-1:0]  padded;
    logic [TOTAL_W-1:0] remain;
    logic               do_pop;
    logic               can_emit;

    assign pcount = total_reg[2:0];
    assign pmask = (BYTE_W'(1) << pcount) - BYTE_W'(1);
    assign part = acc_reg[PART_W-1:0] & pmask[PART_W-1:0];
    assign pad_shift = 4'd8 - {1'b0, pcount};
    assign padded = BYTE_W'({1'b0, part} << pad_shift);
    assign remain = total_reg - TOTAL_W'(BYTE_W);
    assign pop_ready = (state_reg == ST_IDLE);
    assign do_pop = pop_valid && pop_ready;
    assign can_emit = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        acc_next = acc_reg;
        total_next = total_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (do_pop)
                begin
                    if (pop_entry.flush)
                    begin
                        acc_next = ACC_W'(padded);
                        total_next = (pcount != 3'd0) ? TOTAL_W'(BYTE_W) : '0;
                    end
                    else
                    begin
                        acc_next = (ACC_W'(part) << pop_entry.len) | ACC_W'(pop_entry.code);
                        total_next = TOTAL_W'(pcount) + pop_entry.len;
                    end
                    if (total_next >= TOTAL_W'(BYTE_W))
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    ovalid_next = 1'b1;
                    obyte_next = BYTE_W'(acc_reg >> remain);
                    olast_next = (remain < TOTAL_W'(BYTE_W));
                    total_next = remain;
                    if (remain < TOTAL_W'(BYTE_W))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg <= '0;
            total_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg <= acc_next;
            total_reg <= total_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign out_byte = obyte_reg;
    assign out_last = olast_reg;
    assign stat.busy = (state_reg == ST_EMIT);
    assign stat.pending = total_reg;

endmodule

// ===== src/huffman_code_bit_packer.sv =====
// Top level of the Huffman code bit packer: front end, queue and packing back end.
// Depends on hcbp_pkg, hcbp_front, hcbp_queue and hcbp_back.
//
// Requests arrive on the s_axis channel. A load request writes one symbol's code
// word and length into the code table, an encode request appends the symbol's
// code bits to the bit accumulator, and a flush request pads a partial byte with
// zeros, sends it and empties the accumulator. Packed bytes leave on the m_axis
// channel, earliest bit in the most significant position, with tlast set on the
// final byte that a request produces. Loads, empty flushes and encodes that
// complete no byte produce nothing on m_axis.
// The front end takes one request per cycle while the queue has room. The back
// end takes a request from the queue only when idle, then emits its bytes one
// per cycle unless m_axis_tready stalls it. A request passes the front end's read
// register, the queue and the accumulator before its first byte enters the output register.
// Reset empties the queue and the accumulator; the code table is not cleared and
// an entry must be loaded before it is encoded. When m_axis_tready is low the
// output register holds its byte, the back end waits and the queue fills, after
// which s_axis_tready falls.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], symbol[9:2], code_word[41:10], code_length[47:42]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);
    import hcbp_pkg::*;

    logic              push_valid;
    logic              push_ready;
    hcbp_entry_t       push_entry;
    logic              pop_valid;
    logic              pop_ready;
    hcbp_entry_t       pop_entry;
    logic [QCNT_W-1:0] q_count;
    hcbp_stat_t        stat;

    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .action      (s_axis_tdata[1:0]),
        .symbol      (s_axis_tdata[9:2]),
        .code_word   (s_axis_tdata[41:10]),
        .code_length (s_axis_tdata[47:42]),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    hcbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .count      (q_count)
    );

    hcbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .stat      (stat)
    );

`ifndef NO_ASSERTIONS
    a_busy_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> (stat.pending >= TOTAL_W'(BYTE_W)))
        else $error("Back end is emitting with fewer than eight pending bits.");

    a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.busy |-> (stat.pending < TOTAL_W'(BYTE_W)))
        else $error("Back end is idle with a whole byte still pending.");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue holds more entries than its depth.");
`endif

endmodule

// ===== tb/huffman_code_bit_packer_checker.sv =====
// Checker for the Huffman code bit packer: watches both streams, predicts the packed bytes
// of every accepted request and compares them in order. Depends on hcbp_pkg.
module huffman_code_bit_packer_checker #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // action[1:0], symbol[9:2], code_word[41:10], code_length[47:42]
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0]
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    localparam int CODE_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [LEN_W-1:0]    code_length;
        logic [CODE_W-1:0]   code_word;
        logic [SYM_W-1:0]    symbol;
        logic [ACTION_W-1:0] action;
    } request_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } packed_byte_t;

    logic [CODE_W-1:0] code_bits [256];
    int                code_len [256];
    logic [PART_W-1:0] pending_bits;
    int                pending_count;
    packed_byte_t      expected_bytes[$];
    int                mismatches = 0;
    int                backlog = 0;

    assign fail_count = mismatches;
    assign outstanding = backlog;

    task pack_request(input request_t req);
        logic [63:0]      keep;
        logic [ACC_W-1:0] acc;
        int               len;
        int               total;
        int               produced;
        packed_byte_t     b;
        begin
            case (req.action)
                ACT_LOAD:
                begin
                    if (int'(req.symbol) < SYMBOL_COUNT)
                    begin
                        len = (int'(req.code_length) > CODE_LIMIT) ? CODE_LIMIT
                                                                  : int'(req.code_length);
                        keep = (64'd1 << len) - 64'd1;
                        code_bits[req.symbol] = req.code_word & keep[CODE_W-1:0];
                        code_len[req.symbol] = len;
                    end
                end
                ACT_ENCODE:
                begin
                    len = 0;
                    acc = ACC_W'(pending_bits);
                    if (int'(req.symbol) < SYMBOL_COUNT)
                    begin
                        len = code_len[req.symbol];
                        acc = (acc << len) | ACC_W'(code_bits[req.symbol]);
                    end
                    total = pending_count + len;
                    produced = 0;
                    while (total >= BYTE_W && produced < 4)
                    begin
                        b.out_byte = BYTE_W'(acc >> (total - BYTE_W));
                        b.last = 1'b0;
                        expected_bytes.push_back(b);
                        produced++;
                        total -= BYTE_W;
                    end
                    if (produced > 0)
                    begin
                        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
                    end
                    pending_bits = PART_W'(acc & ((ACC_W'(1) << total) - ACC_W'(1)));
                    pending_count = total;
                end
                ACT_FLUSH:
                begin
                    if (pending_count != 0)
                    begin
                        b.out_byte = BYTE_W'({1'b0, pending_bits} << (BYTE_W - pending_count));
                        b.last = 1'b1;
                        expected_bytes.push_back(b);
                    end
                    pending_bits = '0;
                    pending_count = 0;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        packed_byte_t head;
        if (!rst_n)
        begin
            expected_bytes.delete();
            pending_bits = '0;
            pending_count = 0;
            backlog <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("unexpected byte %02h last %b", m_axis_tdata, m_axis_tlast);
                    end
                end
                else
                begin
                    head = expected_bytes.pop_front();
                    if (head.out_byte !== m_axis_tdata || head.last !== m_axis_tlast)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("byte mismatch: expected %02h last %b, got %02h last %b",
                                     head.out_byte, head.last, m_axis_tdata, m_axis_tlast);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pack_request(request_t'(s_axis_tdata));
            end
            backlog <= expected_bytes.size();
        end
    end

endmodule

// ===== tb/huffman_code_bit_packer_tb.sv =====
// Top of the Huffman code bit packer testbench: clock, reset, request stimulus, output back-pressure and verdict.
// Depends on hcbp_pkg, huffman_code_bit_packer and huffman_code_bit_packer_checker.
module huffman_code_bit_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbp_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire [7:0]   m_axis_tdata;
    wire         m_axis_tlast;

    logic        stalls_on = 1'b1;
    int          cycle_count = 0;
    int          fail_count;
    int          outstanding;
    bit          loaded [256];
    int          loaded_symbols[$];

    huffman_code_bit_packer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    huffman_code_bit_packer_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && (!stalls_on || $urandom_range(99) >= 20);
    end

    task send_request(input logic [ACTION_W-1:0] act, input logic [SYM_W-1:0] sym,
                      input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
        begin
            while (stalls_on && $urandom_range(99) < 20)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {len, word, sym, act};
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
            if (act == ACT_LOAD && !loaded[sym])
            begin
                loaded[sym] = 1'b1;
                loaded_symbols.push_back(int'(sym));
            end
        end
    endtask

    task drain_results;
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0) @(posedge clk);
        end
    endtask

    task random_request(output bit counted);
        int                  pick;
        int                  shape;
        logic [ACTION_W-1:0] act;
        logic [SYM_W-1:0]    sym;
        logic [LEN_W-1:0]    len;
        begin
            pick = $urandom_range(99);
            sym = SYM_W'($urandom_range(255));
            len = LEN_W'($urandom_range(63));
            if (pick < 25 || loaded_symbols.size() == 0)
            begin
                act = ACT_LOAD;
                shape = $urandom_range(99);
                if (shape < 5)
                    len = '0;
                else if (shape < 12)
                    len = LEN_W'($urandom_range(63, 33));
                else if (shape < 45)
                    len = LEN_W'($urandom_range(8, 1));
                else
                    len = LEN_W'($urandom_range(32, 1));
            end
            else if (pick < 80)
            begin
                act = ACT_ENCODE;
                sym = SYM_W'(loaded_symbols[$urandom_range(loaded_symbols.size() - 1)]);
            end
            else if (pick < 92)
                act = ACT_FLUSH;
            else
                act = ACT_UNUSED;
            send_request(act, sym, $urandom(), len);
            counted = (act != ACT_UNUSED);
        end
    endtask

    initial
    begin
        int accepted;
        bit counted;
        bit paused;
        accepted = 0;
        paused = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ACT_FLUSH, 8'd0, 32'd0, 6'd0);
        send_request(ACT_LOAD, 8'd0, 32'h0000_0001, 6'd1);
        send_request(ACT_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
        send_request(ACT_LOAD, 8'd85, 32'hA5A5_A5A5, 6'd63);
        send_request(ACT_LOAD, 8'd170, 32'hFFFF_FFFF, 6'd0);
        send_request(ACT_LOAD, 8'd1, 32'h0000_0000, 6'd8);
        send_request(ACT_LOAD, 8'd2, 32'hDEAD_BEEF, 6'd7);
        send_request(ACT_LOAD, 8'd3, 32'h1234_5678, 6'd33);
        send_request(ACT_LOAD, 8'd4, 32'h0000_0000, 6'd32);
        send_request(ACT_ENCODE, 8'd0, 32'd0, 6'd0);
        send_request(ACT_ENCODE, 8'd255, 32'd0, 6'd0);
        send_request(ACT_ENCODE, 8'd170, 32'd0, 6'd0);
        send_request(ACT_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
        send_request(ACT_ENCODE, 8'd85, 32'd0, 6'd0);
        send_request(ACT_FLUSH, 8'd0, 32'd0, 6'd0);
        send_request(ACT_FLUSH, 8'd0, 32'd0, 6'd0);
        send_request(ACT_ENCODE, 8'd1, 32'd0, 6'd0);
        send_request(ACT_ENCODE, 8'd2, 32'd0, 6'd0);
        send_request(ACT_ENCODE, 8'd0, 32'd0, 6'd0);
        send_request(ACT_ENCODE, 8'd3, 32'd0, 6'd0);
        send_request(ACT_ENCODE, 8'd4, 32'd0, 6'd0);
        send_request(ACT_FLUSH, 8'd0, 32'd0, 6'd0);
        drain_results();

        while (accepted < RANDOM_REQUESTS)
        begin
            stalls_on <= !(accepted >= 150 && accepted < 300);
            if (accepted == 250 && !paused)
            begin
                paused = 1'b1;
                drain_results();
            end
            random_request(counted);
            if (counted)
                accepted++;
        end
        stalls_on <= 1'b1;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== huffman_code_bit_packer.f =====
src/hcbp_pkg.sv
src/hcbp_front.sv
src/hcbp_queue.sv
src/hcbp_back.sv
src/huffman_code_bit_packer.sv
tb/huffman_code_bit_packer_checker.sv
tb/huffman_code_bit_packer_tb.sv
